/* rtl/core/apbc_pkg.sv */
// ----------------------------------------------------------------------------
// apbc_pkg
// Shared types and constants of the audio driven buck controller.
// ----------------------------------------------------------------------------
package apbc_pkg;

    // fixed scaling constants of the control loop
    localparam logic [31:0] CENTRE_CODE = 32'd2048;
    localparam logic [31:0] COEFF_ONE   = 32'd256;
    localparam logic [31:0] VOLT_SCALE  = 32'd4800;

    // register indexes of the configuration port
    localparam logic [3:0] REG_FILTER_COEFF  = 4'd0;
    localparam logic [3:0] REG_VOLUME_GAIN   = 4'd1;
    localparam logic [3:0] REG_TARGET_OFFSET = 4'd2;
    localparam logic [3:0] REG_PROP_GAIN     = 4'd3;
    localparam logic [3:0] REG_INTEG_GAIN    = 4'd4;
    localparam logic [3:0] REG_INTEG_LIMIT   = 4'd5;
    localparam logic [3:0] REG_DUTY_MAX      = 4'd6;
    localparam logic [3:0] REG_DUTY_MIN      = 4'd7;

    // register reset values
    localparam logic [8:0]  RST_FILTER_COEFF  = 9'd100;
    localparam logic [7:0]  RST_VOLUME_GAIN   = 8'd30;
    localparam logic [24:0] RST_TARGET_OFFSET = 25'd8039075;
    localparam logic [7:0]  RST_PROP_GAIN     = 8'd3;
    localparam logic [7:0]  RST_INTEG_GAIN    = 8'd7;
    localparam logic [27:0] RST_INTEG_LIMIT   = 28'd134217728;
    localparam logic [15:0] RST_DUTY_MAX      = 16'hFFFF;
    localparam logic [15:0] RST_DUTY_MIN      = 16'h0000;

    // post-multiply arithmetic shift of the shared unit
    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_8    = 2'd1,
        SH_16   = 2'd2
    } t_shift;

    // one operation of the shared multiply-shift-add unit
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        t_shift      sh;
    } t_mac_op;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FILT1 = 9'b000000010,
        ST_FILT2 = 9'b000000100,
        ST_TGT   = 9'b000001000,
        ST_ERR   = 9'b000010000,
        ST_INTEG = 9'b000100000,
        ST_LIMIT = 9'b001000000,
        ST_DUTY  = 9'b010000000,
        ST_CLAMP = 9'b100000000
    } t_state;

endpackage

/* rtl/core/apbc_in_if.sv */
// ----------------------------------------------------------------------------
// apbc_in_if
// Sample channel: one audio and one voltage converter reading per transfer.
// ----------------------------------------------------------------------------
interface apbc_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] audio_sample;
    logic [11:0] voltage_sample;

    modport source (output valid, output audio_sample, output voltage_sample, input ready);
    modport sink   (input valid, input audio_sample, input voltage_sample, output ready);
endinterface

/* rtl/core/apbc_out_if.sv */
// ----------------------------------------------------------------------------
// apbc_out_if
// Duty channel: clamped duty value and status flags per transfer.
// ----------------------------------------------------------------------------
interface apbc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty_value;
    logic        clamped_high;
    logic        clamped_low;
    logic        integ_held;

    modport source (output valid, output duty_value, output clamped_high,
                    output clamped_low, output integ_held, input ready);
    modport sink   (input valid, input duty_value, input clamped_high,
                    input clamped_low, input integ_held, output ready);
endinterface

/* rtl/core/apbc_mac.sv */
// ----------------------------------------------------------------------------
// apbc_mac
// Shared 32-bit multiply, arithmetic shift and add: y = ((a*b) >>> sh) + c.
// ----------------------------------------------------------------------------
module apbc_mac (
    input  apbc_pkg::t_mac_op i_op,
    output logic [31:0]       o_y
);

    logic        [31:0] w_prod;
    logic signed [31:0] w_shift;

    // product wraps at 32 bits
    assign w_prod = i_op.a * i_op.b;

    // arithmetic shift keeps the sign
    always_comb begin
        case (i_op.sh)
            apbc_pkg::SH_8:  w_shift = $signed(w_prod) >>> 8;
            apbc_pkg::SH_16: w_shift = $signed(w_prod) >>> 16;
            default:         w_shift = $signed(w_prod);
        endcase
    end

    assign o_y = w_shift + i_op.c;

endmodule

/* rtl/core/audio_pi_buck_controller.sv */
// ----------------------------------------------------------------------------
// audio_pi_buck_controller
// PI duty controller for a buck stage driven by a low-pass filtered audio
// target. Each sample pair is taken, the work runs through one shared
// multiply-shift-add unit under a small sequencer, and one duty result is
// produced per sample. A result is valid once its sample has gone through
// the sequencer: seven sequencer steps each make one pass through the shared
// 32x32 multiply-shift-add unit, and a final clamp step loads the output
// register. The input is not ready while a sample is at work; a finished
// result waits in the output register and the next sample is accepted
// meanwhile, the final clamp step only holding when an earlier result has
// still not been taken. Registers are written through a plain write port
// while the block is idle: a rule for the user, the block itself does not
// enforce it. Indexes above 7 are ignored.
// ----------------------------------------------------------------------------
module audio_pi_buck_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_idx,
    input  logic [27:0]        i_cfg_data,
    apbc_in_if.sink            i_in,
    apbc_out_if.source         o_out
);

    // configuration registers
    logic [8:0]  r_filter_coeff;
    logic [7:0]  r_volume_gain;
    logic [24:0] r_target_offset;
    logic [7:0]  r_prop_gain;
    logic [7:0]  r_integ_gain;
    logic [27:0] r_integ_limit;
    logic [15:0] r_duty_max;
    logic [15:0] r_duty_min;

    // loop state and working registers
    apbc_pkg::t_state r_state, n_state;
    logic [31:0] r_fs;
    logic [28:0] r_integ;
    logic [31:0] r_acc;
    logic [31:0] r_err;
    logic [11:0] r_audio;
    logic [11:0] r_volt;
    logic        r_held;

    // output register
    logic        r_out_valid;
    logic [15:0] r_duty_value;
    logic        r_clamped_high;
    logic        r_clamped_low;
    logic        r_integ_held;

    apbc_pkg::t_mac_op w_op;
    logic [31:0]        w_y;
    logic signed [31:0] w_lim;
    logic               w_held;
    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_hi;
    logic               w_lo;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == apbc_pkg::ST_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_coeff  <= apbc_pkg::RST_FILTER_COEFF;
            r_volume_gain   <= apbc_pkg::RST_VOLUME_GAIN;
            r_target_offset <= apbc_pkg::RST_TARGET_OFFSET;
            r_prop_gain     <= apbc_pkg::RST_PROP_GAIN;
            r_integ_gain    <= apbc_pkg::RST_INTEG_GAIN;
            r_integ_limit   <= apbc_pkg::RST_INTEG_LIMIT;
            r_duty_max      <= apbc_pkg::RST_DUTY_MAX;
            r_duty_min      <= apbc_pkg::RST_DUTY_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apbc_pkg::REG_FILTER_COEFF:  r_filter_coeff  <= i_cfg_data[8:0];
                apbc_pkg::REG_VOLUME_GAIN:   r_volume_gain   <= i_cfg_data[7:0];
                apbc_pkg::REG_TARGET_OFFSET: r_target_offset <= i_cfg_data[24:0];
                apbc_pkg::REG_PROP_GAIN:     r_prop_gain     <= i_cfg_data[7:0];
                apbc_pkg::REG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data[7:0];
                apbc_pkg::REG_INTEG_LIMIT:   r_integ_limit   <= i_cfg_data;
                apbc_pkg::REG_DUTY_MAX:      r_duty_max      <= i_cfg_data[15:0];
                apbc_pkg::REG_DUTY_MIN:      r_duty_min      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // operand selection for the shared unit
    always_comb begin
        w_op = '{a: 32'd0, b: 32'd0, c: 32'd0, sh: apbc_pkg::SH_NONE};
        unique case (r_state)
            apbc_pkg::ST_FILT1: begin
                w_op.a  = {23'd0, r_filter_coeff};
                w_op.b  = r_fs;
                w_op.sh = apbc_pkg::SH_8;
            end
            apbc_pkg::ST_FILT2: begin
                w_op.a = apbc_pkg::COEFF_ONE - {23'd0, r_filter_coeff};
                w_op.b = {20'd0, r_audio} - apbc_pkg::CENTRE_CODE;
                w_op.c = r_acc;
            end
            apbc_pkg::ST_TGT: begin
                w_op.a = r_fs;
                w_op.b = {24'd0, r_volume_gain};
                w_op.c = {{7{r_target_offset[24]}}, r_target_offset};
            end
            apbc_pkg::ST_ERR: begin
                w_op.a = {20'd0, r_volt};
                w_op.b = 32'd0 - apbc_pkg::VOLT_SCALE;
                w_op.c = r_acc;
            end
            apbc_pkg::ST_INTEG: begin
                w_op.a = r_err;
                w_op.b = 32'd1;
                w_op.c = {{3{r_integ[28]}}, r_integ};
            end
            apbc_pkg::ST_LIMIT: begin
                w_op.a  = {24'd0, r_prop_gain};
                w_op.b  = r_err;
                w_op.sh = apbc_pkg::SH_16;
            end
            apbc_pkg::ST_DUTY: begin
                w_op.a  = {24'd0, r_integ_gain};
                w_op.b  = {{3{r_integ[28]}}, r_integ};
                w_op.c  = r_acc;
                w_op.sh = apbc_pkg::SH_16;
            end
            default: ;
        endcase
    end

    apbc_mac u_mac (
        .i_op (w_op),
        .o_y  (w_y)
    );

    // integrator bound test on the candidate sum, strict on both sides
    assign w_lim  = $signed({4'd0, r_integ_limit});
    assign w_held = !(($signed(r_acc) < w_lim) && ($signed(r_acc) > -w_lim));

    // duty clamp, high bound checked first
    assign w_hi = $signed(r_acc) >= $signed({16'd0, r_duty_max});
    assign w_lo = !w_hi && ($signed(r_acc) <= $signed({16'd0, r_duty_min}));

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apbc_pkg::ST_IDLE:  if (w_in_xfer) n_state = apbc_pkg::ST_FILT1;
            apbc_pkg::ST_FILT1: n_state = apbc_pkg::ST_FILT2;
            apbc_pkg::ST_FILT2: n_state = apbc_pkg::ST_TGT;
            apbc_pkg::ST_TGT:   n_state = apbc_pkg::ST_ERR;
            apbc_pkg::ST_ERR:   n_state = apbc_pkg::ST_INTEG;
            apbc_pkg::ST_INTEG: n_state = apbc_pkg::ST_LIMIT;
            apbc_pkg::ST_LIMIT: n_state = apbc_pkg::ST_DUTY;
            apbc_pkg::ST_DUTY:  n_state = apbc_pkg::ST_CLAMP;
            apbc_pkg::ST_CLAMP: if (w_out_free) n_state = apbc_pkg::ST_IDLE;
            default:            n_state = apbc_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apbc_pkg::ST_IDLE;
            r_fs        <= 32'd0;
            r_integ     <= 29'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == apbc_pkg::ST_FILT2) begin
                r_fs <= w_y;
            end
            if (r_state == apbc_pkg::ST_LIMIT && !w_held) begin
                r_integ <= r_acc[28:0];
            end
            if (r_state == apbc_pkg::ST_CLAMP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_audio <= i_in.audio_sample;
            r_volt  <= i_in.voltage_sample;
        end
        if (r_state == apbc_pkg::ST_FILT1 || r_state == apbc_pkg::ST_TGT
            || r_state == apbc_pkg::ST_ERR || r_state == apbc_pkg::ST_INTEG
            || r_state == apbc_pkg::ST_LIMIT || r_state == apbc_pkg::ST_DUTY) begin
            r_acc <= w_y;
        end
        if (r_state == apbc_pkg::ST_ERR) begin
            r_err <= w_y;
        end
        if (r_state == apbc_pkg::ST_LIMIT) begin
            r_held <= w_held;
        end
        if (r_state == apbc_pkg::ST_CLAMP && w_out_free) begin
            r_clamped_high <= w_hi;
            r_clamped_low  <= w_lo;
            r_integ_held   <= r_held;
            if (w_hi) begin
                r_duty_value <= r_duty_max;
            end else if (w_lo) begin
                r_duty_value <= r_duty_min;
            end else begin
                r_duty_value <= r_acc[15:0];
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.duty_value   = r_duty_value;
    assign o_out.clamped_high = r_clamped_high;
    assign o_out.clamped_low  = r_clamped_low;
    assign o_out.integ_held   = r_integ_held;

    // a held integrator keeps its value
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == apbc_pkg::ST_LIMIT && w_held) |=> $stable(r_integ))
        else $error("integrator changed while held");

    // a pending result blocks the clamp step
    a_clamp_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == apbc_pkg::ST_CLAMP && r_out_valid && !o_out.ready)
        |=> (r_state == apbc_pkg::ST_CLAMP))
        else $error("clamp step overwrote a pending result");

    // clamp flags are exclusive
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.clamped_high && o_out.clamped_low))
        else $error("both clamp flags set");

    // no sample is taken while one is at work
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_in.ready)
        else $error("input ready while busy");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the audio driven PI buck duty controller. Samples
// go in bursts with random gaps while the duty side stalls on its own
// pattern. A scoreboard keeps its own copy of the filter and integrator state
// and of the registers, works out each duty result as a sample transfer is
// accepted, and compares it with what comes out, in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_ITEMS  = 85;
    localparam logic [31:0] MID_CODE     = 32'd2048;
    localparam logic [31:0] UNITY_WEIGHT = 32'd256;
    localparam logic [31:0] MV_PER_CODE  = 32'd4800;

    // one duty result as seen on the output channel
    typedef struct packed {
        logic [15:0] duty;
        logic        hi;
        logic        lo;
        logic        held;
    } t_duty_res;

    // duty predictor with its own loop state and register copy
    class duty_scoreboard;
        logic [8:0]  coeff;
        logic [7:0]  vgain;
        logic [24:0] offset;
        logic [7:0]  pgain;
        logic [7:0]  igain;
        logic [27:0] limit;
        logic [15:0] dmax;
        logic [15:0] dmin;
        logic [31:0] lp_state;
        logic [31:0] integ;
        t_duty_res   expq[$];
        int          errors;

        function void reset();
            coeff    = 9'd100;
            vgain    = 8'd30;
            offset   = 25'd8039075;
            pgain    = 8'd3;
            igain    = 8'd7;
            limit    = 28'd134217728;
            dmax     = 16'hFFFF;
            dmin     = 16'h0000;
            lp_state = '0;
            integ    = '0;
            expq.delete();
            errors   = 0;
        endfunction

        function logic [31:0] asr(logic [31:0] x, int n);
            logic signed [31:0] s;
            s = x;
            return s >>> n;
        endfunction

        function void write_reg(logic [3:0] idx, logic [27:0] data);
            case (idx)
                apbc_pkg::REG_FILTER_COEFF:  coeff  = data[8:0];
                apbc_pkg::REG_VOLUME_GAIN:   vgain  = data[7:0];
                apbc_pkg::REG_TARGET_OFFSET: offset = data[24:0];
                apbc_pkg::REG_PROP_GAIN:     pgain  = data[7:0];
                apbc_pkg::REG_INTEG_GAIN:    igain  = data[7:0];
                apbc_pkg::REG_INTEG_LIMIT:   limit  = data;
                apbc_pkg::REG_DUTY_MAX:      dmax   = data[15:0];
                apbc_pkg::REG_DUTY_MIN:      dmin   = data[15:0];
                default: ;
            endcase
        endfunction

        // one control step per accepted sample pair
        function void note_sample(logic [11:0] audio, logic [11:0] volt);
            logic [31:0] off32;
            logic [31:0] prod;
            logic [31:0] err;
            logic [31:0] nxt;
            logic [31:0] duty;
            int          snext;
            int          slim;
            int          sduty;
            int          smax;
            int          smin;
            t_duty_res   r;
            off32    = {{7{offset[24]}}, offset};
            prod     = {23'b0, coeff} * lp_state;
            lp_state = asr(prod, 8)
                     + (UNITY_WEIGHT - {23'b0, coeff}) * ({20'b0, audio} - MID_CODE);
            err      = lp_state * {24'b0, vgain} + off32 - {20'b0, volt} * MV_PER_CODE;
            // integrator moves only while strictly inside the bound
            nxt      = err + integ;
            snext    = nxt;
            slim     = {4'b0, limit};
            r.held   = !(snext < slim && snext > -slim);
            if (!r.held) integ = nxt;
            prod     = {24'b0, pgain} * err;
            duty     = asr(prod, 16);
            prod     = {24'b0, igain} * integ;
            duty     = duty + asr(prod, 16);
            // high bound wins when the bounds cross
            sduty    = duty;
            smax     = {16'b0, dmax};
            smin     = {16'b0, dmin};
            r.hi     = 1'b0;
            r.lo     = 1'b0;
            if (sduty >= smax) begin
                r.duty = dmax;
                r.hi   = 1'b1;
            end else if (sduty <= smin) begin
                r.duty = dmin;
                r.lo   = 1'b1;
            end else begin
                r.duty = duty[15:0];
            end
            expq.push_back(r);
        endfunction

        function void check_duty(t_duty_res got);
            t_duty_res want;
            if (expq.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected duty transfer duty=%h hi=%b lo=%b held=%b",
                             $time, got.duty, got.hi, got.lo, got.held);
                return;
            end
            want = expq.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp duty=%h hi=%b lo=%b held=%b",
                             $time, want.duty, want.hi, want.lo, want.held,
                             " got duty=%h hi=%b lo=%b held=%b",
                             got.duty, got.hi, got.lo, got.held);
            end
        endfunction

        function int pending();
            return expq.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_idx;
    logic [27:0] cfg_data;
    int          cycles = 0;
    int          rdy_mode = 0;
    int          rdy_left = 0;

    apbc_in_if  smp_if ();
    apbc_out_if duty_if ();

    duty_scoreboard sb = new();

    audio_pi_buck_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (smp_if),
        .o_out      (duty_if)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("audio_pi_buck_controller regression: fail");
            $finish;
        end
    end

    // duty side: check transfers, stall on a changing pattern
    always @(posedge i_clk) begin
        if (i_rst_n && duty_if.valid && duty_if.ready)
            sb.check_duty({duty_if.duty_value, duty_if.clamped_high,
                           duty_if.clamped_low, duty_if.integ_held});
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(1, 24);
        end else begin
            rdy_left = rdy_left - 1;
        end
        case (rdy_mode)
            0:       duty_if.ready <= 1'b1;
            1:       duty_if.ready <= $urandom_range(0, 1);
            2:       duty_if.ready <= 1'b0;
            default: duty_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic write_reg(logic [3:0] idx, logic [27:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // all registers plus one write to an unused index
    task automatic program_all(logic [8:0] c, logic [7:0] g, logic [24:0] o,
                               logic [7:0] p, logic [7:0] ig, logic [27:0] l,
                               logic [15:0] mx, logic [15:0] mn);
        write_reg(apbc_pkg::REG_FILTER_COEFF, {19'b0, c});
        write_reg(apbc_pkg::REG_VOLUME_GAIN, {20'b0, g});
        write_reg(apbc_pkg::REG_TARGET_OFFSET, {3'b0, o});
        write_reg(apbc_pkg::REG_PROP_GAIN, {20'b0, p});
        write_reg(apbc_pkg::REG_INTEG_GAIN, {20'b0, ig});
        write_reg(apbc_pkg::REG_INTEG_LIMIT, l);
        write_reg(apbc_pkg::REG_DUTY_MAX, {12'b0, mx});
        write_reg(apbc_pkg::REG_DUTY_MIN, {12'b0, mn});
        write_reg(4'($urandom_range(8, 15)), 28'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // drain the pipeline before touching registers
    task automatic quiesce();
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // one sample transfer, valid left high afterwards
    task automatic send_sample(logic [11:0] a, logic [11:0] v);
        smp_if.valid          <= 1'b1;
        smp_if.audio_sample   <= a;
        smp_if.voltage_sample <= v;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sb.note_sample(a, v);
    endtask

    function automatic logic [7:0] pick_gain(logic [7:0] dflt);
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom_range(0, 255));
            default: return dflt;
        endcase
    endfunction

    function automatic logic [15:0] pick_bound(logic [15:0] dflt);
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return dflt;
        endcase
    endfunction

    task automatic random_settings();
        logic [8:0]  c;
        logic [24:0] o;
        logic [27:0] l;
        case ($urandom_range(0, 7))
            0:       c = 9'd0;
            1:       c = 9'd256;
            2:       c = 9'd511;
            3:       c = 9'($urandom_range(257, 511));
            4:       c = 9'd100;
            default: c = 9'($urandom_range(0, 256));
        endcase
        case ($urandom_range(0, 5))
            0:       o = 25'h1000000;
            1:       o = 25'h0FFFFFF;
            2:       o = 25'($urandom_range(0, 33554431));
            default: o = 25'(8039075 + int'($urandom_range(0, 400000)) - 200000);
        endcase
        case ($urandom_range(0, 6))
            0:       l = 28'd0;
            1:       l = 28'd1;
            2:       l = 28'd134217728;
            3:       l = 28'($urandom_range(1, 1 << 20));
            default: l = 28'($urandom_range(1, 134217728));
        endcase
        program_all(c, pick_gain(8'd30), o, pick_gain(8'd3), pick_gain(8'd7), l,
                    pick_bound(16'hFFFF), pick_bound(16'h0000));
    endtask

    // mostly random codes, some extremes, some voltages near the set point
    task automatic random_sample(output logic [11:0] a, output logic [11:0] v);
        case ($urandom_range(0, 7))
            0:       a = 12'h000;
            1:       a = 12'hFFF;
            default: a = 12'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 7))
            0:       v = 12'h000;
            1:       v = 12'hFFF;
            2, 3, 4: v = 12'($urandom_range(1580, 1780));
            default: v = 12'($urandom_range(0, 4095));
        endcase
    endtask

    task automatic random_phase(int n_items);
        logic [11:0] a;
        logic [11:0] v;
        int          sent;
        int          burst;
        int          gap;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                random_sample(a, v);
                send_sample(a, v);
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            // hold off mid phase until the pipeline has emptied
            if (sent >= n_items / 2 && sent - burst < n_items / 2) begin
                smp_if.valid <= 1'b0;
                while (sb.pending() > 0) @(posedge i_clk);
            end else if (gap > 0) begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_set(logic [11:0] a0, logic [11:0] v0,
                                logic [11:0] a1, logic [11:0] v1);
        send_sample(a0, v0);
        send_sample(a1, v1);
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= '0;
        cfg_data              <= '0;
        smp_if.valid          <= 1'b0;
        smp_if.audio_sample   <= '0;
        smp_if.voltage_sample <= '0;
        sb.reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, field extremes
        directed_set(12'h000, 12'h000, 12'hFFF, 12'hFFF);
        directed_set(12'h800, 12'h000, 12'h000, 12'hFFF);
        directed_set(12'hFFF, 12'h000, 12'h800, 12'h800);
        directed_set(12'hAAA, 12'h555, 12'h555, 12'hAAA);
        quiesce();

        // zero gains, both bounds zero: duty equal to the upper bound
        program_all(9'd100, 8'd30, 25'd8039075, 8'd0, 8'd0, 28'd134217728,
                    16'h0000, 16'h0000);
        directed_set(12'h123, 12'h456, 12'hFFF, 12'h000);
        quiesce();

        // zero gains, full range: duty equal to the lower bound
        program_all(9'd100, 8'd30, 25'd8039075, 8'd0, 8'd0, 28'd134217728,
                    16'hFFFF, 16'h0000);
        directed_set(12'h000, 12'hFFF, 12'h800, 12'h68B);
        quiesce();

        // crossed bounds, zero limit, weight above unity
        program_all(9'd300, 8'd255, 25'h0FFFFFF, 8'd255, 8'd255, 28'd0,
                    16'd10, 16'd5000);
        directed_set(12'hFFF, 12'h000, 12'h000, 12'hFFF);
        directed_set(12'h800, 12'h68B, 12'hFFF, 12'hFFF);
        quiesce();

        // upper extremes, tightest limit
        program_all(9'd256, 8'd255, 25'h1000000, 8'd255, 8'd255, 28'd1,
                    16'hFFFF, 16'h0000);
        directed_set(12'h000, 12'h000, 12'hFFF, 12'h000);
        directed_set(12'h800, 12'hFFF, 12'h7FF, 12'h001);
        quiesce();

        // lower extremes
        program_all(9'd0, 8'd0, 25'h0FFFFFF, 8'd0, 8'd1, 28'd134217728,
                    16'hFFFF, 16'h0000);
        directed_set(12'hFFF, 12'h000, 12'h000, 12'h000);
        directed_set(12'h800, 12'hFFF, 12'hFFF, 12'h800);
        quiesce();

        // random phases, the first under reset values
        program_all(9'd100, 8'd30, 25'd8039075, 8'd3, 8'd7, 28'd134217728,
                    16'hFFFF, 16'h0000);
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph > 0) random_settings();
            random_phase(PHASE_ITEMS);
            quiesce();
        end

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("audio_pi_buck_controller regression: pass");
        else
            $display("audio_pi_buck_controller regression: fail");
        $finish;
    end

endmodule
